>>> hdl/srtf_pkg.sv
`default_nettype none

package srtf_pkg;

   // Table geometry
   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Time counter limit
   localparam logic [23:0] TIME_MAX = 24'hFF_FFFF;

   // Request operations; the spare code is taken and dropped
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   // Response status codes
   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_RAN     = 3'd2;
   localparam logic [2:0] ST_IDLE    = 3'd3;
   localparam logic [2:0] ST_CLEARED = 3'd4;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_TURN,
      SEQ_WAIT,
      SEQ_SEND
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  process_id;
      logic [15:0] arrival_time;
      logic [15:0] burst_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  running_id;
      logic [23:0] tick_index;
      logic        finished;
      logic [23:0] completion_time;
      logic [23:0] turnaround_time;
      logic [23:0] waiting_time;
   } rsp_type;

endpackage

`default_nettype wire

>>> hdl/srtf_scheduler_unit.sv
`default_nettype none

// Shortest-remaining-time-first scheduler over a table of process slots.
// Requests arrive on req_valid / req_stall / req_data: an add stores a
// process in the next free slot, a tick runs the best ready process for one
// time unit, a clear empties the table and zeroes the clock. Every add, tick
// and clear yields one response on rsp_valid / rsp_stall / rsp_data; the
// unused operation code is taken and dropped without a response.
// An add or clear goes from acceptance straight to the SEND state.
// A tick walks the slot table through one shared compare unit, one slot per
// cycle, then works out turnaround and waiting time in the TURN and WAIT
// states before SEND, which passes the result to the output register.
// req_stall is high while a transaction is being worked on, so a new request
// is taken only once the previous one has left SEND.
// A response waits in the output register while rsp_stall is high; the next
// request is still taken, and its result is held back until that register
// frees. Reset (synchronous, active high) empties the table, zeroes the
// clock and drops any response in flight.
module srtf_scheduler_unit (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire srtf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output srtf_pkg::rsp_type rsp_data
);

   localparam int IW = srtf_pkg::IDX_W;
   localparam int CW = srtf_pkg::CNT_W;

   // Sequencer and table state
   srtf_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [23:0]             time_ff, time_in;

   logic [7:0]  slot_id_ff  [srtf_pkg::SLOTS];
   logic [15:0] slot_arr_ff [srtf_pkg::SLOTS];
   logic [15:0] slot_bst_ff [srtf_pkg::SLOTS];
   logic [15:0] slot_rem_ff [srtf_pkg::SLOTS];

   // Scan and result working registers
   logic [IW-1:0]     scan_ff, scan_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [7:0]        best_id_ff, best_id_in;
   logic [15:0]       best_arr_ff, best_arr_in;
   logic [15:0]       best_bst_ff, best_bst_in;
   logic [15:0]       best_rem_ff, best_rem_in;
   logic [23:0]       done_ff, done_in;
   srtf_pkg::rsp_type res_ff, res_in;

   logic              rsp_valid_ff, rsp_valid_in;
   srtf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              req_take;
   logic              out_free;
   logic              slot_wr;
   logic              rem_wr;
   logic              eligible;
   logic              better;
   logic [15:0]       cur_arr;
   logic [15:0]       cur_rem;

   assign req_stall = (state_ff != srtf_pkg::SEQ_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Compare the slot under the scan pointer against the best so far
   assign cur_arr  = slot_arr_ff[scan_ff];
   assign cur_rem  = slot_rem_ff[scan_ff];
   assign eligible = (CW'(scan_ff) < count_ff) && (cur_rem != 16'd0) &&
                     ({8'd0, cur_arr} <= res_ff.tick_index);
   assign better   = !found_ff || (cur_rem < best_rem_ff) ||
                     ((cur_rem == best_rem_ff) && (cur_arr < best_arr_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srtf_pkg::SEQ_IDLE: begin
            if (req_take) begin
               case (req_data.op)
                  srtf_pkg::OP_ADD:   state_in = srtf_pkg::SEQ_SEND;
                  srtf_pkg::OP_TICK:  state_in = srtf_pkg::SEQ_SCAN;
                  srtf_pkg::OP_CLEAR: state_in = srtf_pkg::SEQ_SEND;
                  default:            state_in = srtf_pkg::SEQ_IDLE;
               endcase
            end
         end
         srtf_pkg::SEQ_SCAN: begin
            if (scan_ff == IW'(srtf_pkg::SLOTS - 1)) begin
               state_in = srtf_pkg::SEQ_TURN;
            end
         end
         srtf_pkg::SEQ_TURN: state_in = srtf_pkg::SEQ_WAIT;
         srtf_pkg::SEQ_WAIT: state_in = srtf_pkg::SEQ_SEND;
         srtf_pkg::SEQ_SEND: begin
            if (out_free) begin
               state_in = srtf_pkg::SEQ_IDLE;
            end
         end
         default: state_in = srtf_pkg::SEQ_IDLE;
      endcase
   end

   // Datapath and output values
   always_comb begin
      count_in     = count_ff;
      time_in      = time_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_id_in   = best_id_ff;
      best_arr_in  = best_arr_ff;
      best_bst_in  = best_bst_ff;
      best_rem_in  = best_rem_ff;
      done_in      = done_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      slot_wr      = 1'b0;
      rem_wr       = 1'b0;

      // drop a response once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         srtf_pkg::SEQ_IDLE: begin
            if (req_take) begin
               res_in = '0;
               case (req_data.op)
                  srtf_pkg::OP_ADD: begin
                     if (count_ff == CW'(srtf_pkg::SLOTS)) begin
                        res_in.status = srtf_pkg::ST_FULL;
                     end else begin
                        res_in.status = srtf_pkg::ST_ADDED;
                        slot_wr       = 1'b1;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  srtf_pkg::OP_TICK: begin
                     res_in.tick_index = time_ff;
                     scan_in           = '0;
                     found_in          = 1'b0;
                     done_in = (time_ff == srtf_pkg::TIME_MAX) ?
                               srtf_pkg::TIME_MAX : time_ff + 24'd1;
                  end
                  srtf_pkg::OP_CLEAR: begin
                     res_in.status = srtf_pkg::ST_CLEARED;
                     count_in      = '0;
                     time_in       = '0;
                  end
                  default: ;
               endcase
            end
         end
         srtf_pkg::SEQ_SCAN: begin
            // keep the best ready slot, advance the pointer
            if (eligible && better) begin
               found_in    = 1'b1;
               best_idx_in = scan_ff;
               best_id_in  = slot_id_ff[scan_ff];
               best_arr_in = cur_arr;
               best_bst_in = slot_bst_ff[scan_ff];
               best_rem_in = cur_rem;
            end
            scan_in = scan_ff + IW'(1);
         end
         srtf_pkg::SEQ_TURN: begin
            // run the chosen slot, work out turnaround
            time_in = done_ff;
            if (!found_ff) begin
               res_in.status = srtf_pkg::ST_IDLE;
            end else begin
               res_in.status     = srtf_pkg::ST_RAN;
               res_in.running_id = best_id_ff;
               rem_wr            = 1'b1;
               if (best_rem_ff == 16'd1) begin
                  res_in.finished        = 1'b1;
                  res_in.completion_time = done_ff;
                  res_in.turnaround_time = done_ff - {8'd0, best_arr_ff};
               end
            end
         end
         srtf_pkg::SEQ_WAIT: begin
            // waiting time, clamped at zero
            if (res_ff.finished) begin
               if (res_ff.turnaround_time >= {8'd0, best_bst_ff}) begin
                  res_in.waiting_time = res_ff.turnaround_time - {8'd0, best_bst_ff};
               end else begin
                  res_in.waiting_time = '0;
               end
            end
         end
         srtf_pkg::SEQ_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srtf_pkg::SEQ_IDLE;
         count_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers and slot table
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      best_id_ff  <= best_id_in;
      best_arr_ff <= best_arr_in;
      best_bst_ff <= best_bst_in;
      best_rem_ff <= best_rem_in;
      done_ff     <= done_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (slot_wr) begin
         slot_id_ff[count_ff[IW-1:0]]  <= req_data.process_id;
         slot_arr_ff[count_ff[IW-1:0]] <= req_data.arrival_time;
         slot_bst_ff[count_ff[IW-1:0]] <= req_data.burst_time;
         slot_rem_ff[count_ff[IW-1:0]] <= req_data.burst_time;
      end
      if (rem_wr) begin
         slot_rem_ff[best_idx_ff] <= best_rem_ff - 16'd1;
      end
   end

endmodule

`default_nettype wire
